### sv/bcs3d_pkg.sv
package bcs3d_pkg;

	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int SCALE_W  = 32;
	localparam int DIVD_W   = SCALE_W + FRAC_W;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_TARGET_EXTENT = '0;

	localparam logic [SCALE_W-1:0] TARGET_RESET = SCALE_W'(72090);
	localparam logic [SCALE_W-1:0] SCALE_ONE    = SCALE_W'(1) << FRAC_W;
	localparam logic [SCALE_W-1:0] SCALE_SAT    = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_z;
	} bounds_t;

	typedef struct packed {
		logic              push;
		bounds_t           data;
	} bounds_push_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [COORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

### sv/bcs3d_if.sv
interface bcs3d_vtx_if;
	import bcs3d_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic                      last_point;

	modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface bcs3d_res_if;
	import bcs3d_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] shift_x;
	logic signed [COORD_W-1:0] shift_y;
	logic signed [COORD_W-1:0] shift_z;
	logic [SCALE_W-1:0]        scale_factor;
	logic [COORD_W-1:0]        largest_extent;

	modport source (output valid, shift_x, shift_y, shift_z, scale_factor, largest_extent,
		input ready);
	modport sink (input valid, shift_x, shift_y, shift_z, scale_factor, largest_extent,
		output ready);
endinterface

### sv/bcs3d_front.sv
module bcs3d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	bcs3d_vtx_if.sink              vtx,
	input  logic                   queue_full,
	output bcs3d_pkg::bounds_push_t push
);
	import bcs3d_pkg::*;

	logic signed [COORD_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;
	logic                      seen_q;
	logic                      take;
	bounds_t                   nxt;

	function automatic logic signed [COORD_W-1:0] pick_lo(input logic seed,
		input logic signed [COORD_W-1:0] v, input logic signed [COORD_W-1:0] cur);
		return (seed || (v < cur)) ? v : cur;
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_hi(input logic seed,
		input logic signed [COORD_W-1:0] v, input logic signed [COORD_W-1:0] cur);
		return (seed || (v > cur)) ? v : cur;
	endfunction

	assign vtx.ready = !queue_full;
	assign take      = vtx.valid && vtx.ready;

	// first vertex of a model seeds both bounds
	always_comb begin
		nxt.lo_x = pick_lo(!seen_q, vtx.coord_x, lo_x_q);
		nxt.hi_x = pick_hi(!seen_q, vtx.coord_x, hi_x_q);
		nxt.lo_y = pick_lo(!seen_q, vtx.coord_y, lo_y_q);
		nxt.hi_y = pick_hi(!seen_q, vtx.coord_y, hi_y_q);
		nxt.lo_z = pick_lo(!seen_q, vtx.coord_z, lo_z_q);
		nxt.hi_z = pick_hi(!seen_q, vtx.coord_z, hi_z_q);
	end

	assign push.push = take && vtx.last_point;
	assign push.data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (take) begin
			seen_q <= !vtx.last_point;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lo_x_q <= nxt.lo_x;
			hi_x_q <= nxt.hi_x;
			lo_y_q <= nxt.lo_y;
			hi_y_q <= nxt.hi_y;
			lo_z_q <= nxt.lo_z;
			hi_z_q <= nxt.hi_z;
		end
	end

endmodule

### sv/bcs3d_fifo.sv
module bcs3d_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bcs3d_pkg::bounds_push_t push,
	input  logic                   pop,
	output logic                   full,
	output logic                   not_empty,
	output bcs3d_pkg::bounds_t     head
);
	import bcs3d_pkg::*;

	bounds_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;
	logic                   do_push, do_pop;

	assign full      = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push.push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [FIFO_PTR_W-1:0] inc(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= inc(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.data;
	end

endmodule

### sv/bcs3d_div.sv
module bcs3d_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bcs3d_pkg::div_req_t req,
	output bcs3d_pkg::div_rsp_t rsp
);
	import bcs3d_pkg::*;

	logic [COORD_W-1:0]   rem_q;
	logic [COORD_W-1:0]   dsr_q;
	logic [DIVD_W-1:0]    dvd_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [COORD_W:0]     part;
	logic [COORD_W:0]     trial;
	logic                 fits;

	// restoring division, one quotient bit a cycle
	assign part  = {rem_q, dvd_q[DIVD_W-1]};
	assign trial = part - {1'b0, dsr_q};
	assign fits  = !trial[COORD_W];

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[COORD_W-1:0] : part[COORD_W-1:0];
			dvd_q <= {dvd_q[DIVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

endmodule

### sv/bcs3d_back.sv
module bcs3d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 entry_valid,
	input  bcs3d_pkg::bounds_t   entry,
	output logic                 pop,
	input  logic [bcs3d_pkg::SCALE_W-1:0] target_extent,
	output bcs3d_pkg::div_req_t  div_req,
	input  bcs3d_pkg::div_rsp_t  div_rsp,
	bcs3d_res_if.source          res
);
	import bcs3d_pkg::*;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_EXT  = 5'b00010,
		B_MAX  = 5'b00100,
		B_DIV  = 5'b01000,
		B_OUT  = 5'b10000
	} back_state_t;

	back_state_t          state_q;
	logic [COORD_W-1:0]   ex_q, ey_q, ez_q;
	logic [COORD_W-1:0]   big_q;
	logic [SCALE_W-1:0]   tgt_q, scale_q;
	logic [COORD_W-1:0]   sx_q, sy_q, sz_q;
	logic [COORD_W-1:0]   big_xy, big_n;

	function automatic logic [COORD_W-1:0] extent(input logic signed [COORD_W-1:0] lo,
		input logic signed [COORD_W-1:0] hi);
		logic [COORD_W:0] d;
		d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
		return d[COORD_W-1:0];
	endfunction

	// floor of the negated midpoint, saturated at the largest positive value
	function automatic logic [COORD_W-1:0] center(input logic signed [COORD_W-1:0] lo,
		input logic signed [COORD_W-1:0] hi);
		logic [COORD_W+1:0] sum;
		logic [COORD_W+1:0] neg;
		logic [COORD_W+1:0] half;
		sum  = {{2{lo[COORD_W-1]}}, lo} + {{2{hi[COORD_W-1]}}, hi};
		neg  = -sum;
		half = {neg[COORD_W+1], neg[COORD_W+1:1]};
		if (!half[COORD_W+1] && (half[COORD_W:COORD_W-1] != 2'b00))
			return {1'b0, {(COORD_W-1){1'b1}}};
		return half[COORD_W-1:0];
	endfunction

	assign pop    = (state_q == B_IDLE) && entry_valid;
	assign big_xy = (ex_q > ey_q) ? ex_q : ey_q;
	assign big_n  = (big_xy > ez_q) ? big_xy : ez_q;

	assign div_req.start    = (state_q == B_MAX) && (big_n != '0);
	assign div_req.dividend = {tgt_q, {FRAC_W{1'b0}}};
	assign div_req.divisor  = big_n;

	assign res.valid          = (state_q == B_OUT);
	assign res.shift_x        = sx_q;
	assign res.shift_y        = sy_q;
	assign res.shift_z        = sz_q;
	assign res.scale_factor   = scale_q;
	assign res.largest_extent = big_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: if (entry_valid) state_q <= B_EXT;
				B_EXT:  state_q <= B_MAX;
				B_MAX:  state_q <= (big_n == '0) ? B_OUT : B_DIV;
				B_DIV:  if (div_rsp.done) state_q <= B_OUT;
				B_OUT:  if (res.ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// the queue head is captured at the pop edge
	always_ff @(posedge clk) begin
		if (pop) begin
			ex_q  <= extent(entry.lo_x, entry.hi_x);
			ey_q  <= extent(entry.lo_y, entry.hi_y);
			ez_q  <= extent(entry.lo_z, entry.hi_z);
			sx_q  <= center(entry.lo_x, entry.hi_x);
			sy_q  <= center(entry.lo_y, entry.hi_y);
			sz_q  <= center(entry.lo_z, entry.hi_z);
			tgt_q <= target_extent;
		end
		if (state_q == B_MAX) begin
			big_q <= big_n;
			if (big_n == '0) scale_q <= SCALE_ONE;
		end
		if ((state_q == B_DIV) && div_rsp.done) begin
			scale_q <= (div_rsp.quotient[DIVD_W-1:SCALE_W] != '0) ? SCALE_SAT
				: div_rsp.quotient[SCALE_W-1:0];
		end
	end

endmodule

### sv/bbox_center_scale_3d_top.sv
// channel | dir | handshake     | payload
// vtx     | in  | valid / ready | coord_x, coord_y, coord_z, last_point
// res     | out | valid / ready | shift_x, shift_y, shift_z, scale_factor, largest_extent
// apb     | in  | psel/penable  | target_extent at byte address 0
//
// vertices are taken one per cycle while the queue is not full; the bounds fold is a single compare per bound
// a last vertex queues its bounds (two models deep); the vertex port stalls when full
// a result follows its queue pop through the extents and largest states, then a divider
// wait (48 quotient bits and the done cycle)
// zero extent skips the divider, going from the largest state to output; it waits for res.ready
// arst_n clears control state and sets target_extent to 1.1
module bbox_center_scale_3d_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bcs3d_pkg::PADDR_W-1:0]    paddr,
	input  logic [bcs3d_pkg::PDATA_W-1:0]    pwdata,
	output logic [bcs3d_pkg::PDATA_W-1:0]    prdata,
	output logic                             pready,
	bcs3d_vtx_if.sink                        vtx,
	bcs3d_res_if.source                      res
);
	import bcs3d_pkg::*;

	logic [SCALE_W-1:0] target_q;
	logic               reg_hit;
	bounds_push_t       push;
	bounds_t            head;
	logic               full, not_empty, pop;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_TARGET_EXTENT);
	assign prdata  = reg_hit ? PDATA_W'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			target_q <= pwdata[SCALE_W-1:0];
		end
	end

	bcs3d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx        (vtx),
		.queue_full (full),
		.push       (push)
	);

	bcs3d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	bcs3d_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bcs3d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry_valid   (not_empty),
		.entry         (head),
		.pop           (pop),
		.target_extent (target_q),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.res           (res)
	);

endmodule

### sv/bcs3d_checker.sv
module bcs3d_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_last,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bcs3d_pkg::SCALE_W-1:0] out_scale,
	input logic [bcs3d_pkg::COORD_W-1:0] out_extent
);
	import bcs3d_pkg::*;

	localparam int PEND_MAX = FIFO_DEPTH + 1;
	localparam int PEND_W   = $clog2(PEND_MAX + 2);

	logic [PEND_W-1:0] pend_q;
	logic              in_done, out_done;

	assign in_done  = in_valid && in_ready && in_last;
	assign out_done = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_done, out_done})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != '0))
		else $error("result without a pending last vertex");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(PEND_MAX))
		else $error("more models in flight than the queue holds");

	a_zero_extent_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_extent == '0)) |-> (out_scale == SCALE_ONE))
		else $error("zero extent must give unit scale");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_scale)))
		else $error("stalled result changed");

endmodule

bind bbox_center_scale_3d_top bcs3d_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (vtx.valid),
	.in_ready   (vtx.ready),
	.in_last    (vtx.last_point),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.out_scale  (res.scale_factor),
	.out_extent (res.largest_extent)
);
